// ===== src/mbfr_pkg.sv =====
`default_nettype none
package mbfr_pkg;

    localparam int BUFFER_BYTES   = 256;
    localparam int ADDR_W         = $clog2(BUFFER_BYTES);
    localparam int OFFSET_W       = 11;
    localparam int NBITS_W        = 6;
    localparam int MAX_FIELD_BITS = 32;
    localparam int FIELD_W        = 32;
    localparam int NEXT_W         = 12;
    // a 32-bit field at any bit phase touches at most five bytes
    localparam int FETCH_BYTES    = 5;
    localparam int ACC_W          = FETCH_BYTES * 8;
    localparam int CNT_W          = $clog2(FETCH_BYTES);
    // byte index of the fetch, one bit wider so that it can run past the store
    localparam int FIDX_W         = OFFSET_W - 3 + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [ADDR_W-1:0]   byte_address;
        logic [7:0]          byte_data;
        logic [OFFSET_W-1:0] bit_offset;
        logic [NBITS_W-1:0]  num_bits;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [NEXT_W-1:0]  next_bit_offset;
        logic               width_error;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic write;
        logic load;
        logic fetch;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic req_read;
        logic req_wide;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== src/mbfr_req_if.sv =====
`default_nettype none
interface mbfr_req_if;
    logic             valid;
    logic             ready;
    mbfr_pkg::t_req   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/mbfr_rsp_if.sv =====
`default_nettype none
interface mbfr_rsp_if;
    logic             valid;
    logic             ready;
    mbfr_pkg::t_rsp   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/msb_first_bit_field_reader_unit.sv =====
// MSB-first bit field reader.
// i_req carries requests: op 0 stores byte_data at byte_address of a
// 256-byte store, op 1 reads num_bits bits starting at bit_offset (bit 0 is
// the MSB of byte 0). o_rsp returns one response per read: the field right
// aligned, bit_offset + num_bits, and width_error for widths above 32; a
// refused width gives field 0 and bit_offset. Writes give no response.
// Bytes beyond the store read as zero. A write is stored as it is taken.
// A read fetches five bytes, one byte per cycle through the single
// registered read port, then passes a drain and a load step (states FETCH,
// DRAIN, DONE); the next request is taken once the response is loaded.
// A refused width skips the store reads and goes straight to the load
// step. Requests are taken one at a time.
// The response sits in an output register; a request is still taken while
// an earlier response waits. If the receiver stalls, a read finishes its
// store reads and then waits until the output register frees up.
// Reset clears the controller and the response valid; the store is not
// cleared and must be written before it is read.
`default_nettype none
module msb_first_bit_field_reader_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mbfr_req_if.sink    i_req,
    mbfr_rsp_if.source  o_rsp
);

    mbfr_pkg::t_cmd    w_cmd;
    mbfr_pkg::t_status w_status;
    logic              w_out_valid;
    mbfr_pkg::t_rsp    w_out;

    mbfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mbfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.payload),
        .i_out_ready (o_rsp.ready),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign i_req.ready   = w_cmd.accept;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_out;

endmodule
`default_nettype wire

// ===== src/mbfr_ctrl.sv =====
`default_nettype none
module mbfr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbfr_pkg::t_status i_status,
    output mbfr_pkg::t_cmd         o_cmd
);

    mbfr_pkg::t_state                r_state;
    mbfr_pkg::t_state                n_state;
    logic [mbfr_pkg::CNT_W-1:0]      r_cnt;
    logic [mbfr_pkg::CNT_W-1:0]      n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbfr_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            mbfr_pkg::S_IDLE: begin
                if (i_status.req_valid && i_status.req_read) begin
                    n_state = i_status.req_wide ? mbfr_pkg::S_DONE : mbfr_pkg::S_FETCH;
                end
            end
            mbfr_pkg::S_FETCH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mbfr_pkg::CNT_W'(mbfr_pkg::FETCH_BYTES - 1)) begin
                    n_state = mbfr_pkg::S_DRAIN;
                    n_cnt   = '0;
                end
            end
            // last byte comes out of the store this cycle
            mbfr_pkg::S_DRAIN: begin
                n_state = mbfr_pkg::S_DONE;
            end
            mbfr_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = mbfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbfr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            mbfr_pkg::S_IDLE: begin
                o_cmd.accept = 1'b1;
                o_cmd.write  = i_status.req_valid && !i_status.req_read;
                o_cmd.load   = i_status.req_valid && i_status.req_read;
            end
            mbfr_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            mbfr_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            mbfr_pkg::S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/mbfr_dp.sv =====
`default_nettype none
module mbfr_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbfr_pkg::t_cmd    i_cmd,
    input  wire logic              i_req_valid,
    input  wire mbfr_pkg::t_req    i_req,
    input  wire logic              i_out_ready,
    output mbfr_pkg::t_status      o_status,
    output logic                   o_out_valid,
    output mbfr_pkg::t_rsp         o_out
);

    logic [7:0]                      r_mem [mbfr_pkg::BUFFER_BYTES];
    logic [7:0]                      r_rd_data;
    logic                            r_rd_past;
    logic                            r_cap;
    logic [mbfr_pkg::FIDX_W-1:0]     r_fidx;
    logic [mbfr_pkg::OFFSET_W-1:0]   r_off;
    logic [mbfr_pkg::NBITS_W-1:0]    r_nb;
    logic                            r_err;
    logic [mbfr_pkg::ACC_W-1:0]      r_acc;
    logic                            r_out_valid;
    mbfr_pkg::t_rsp                  r_out;
    mbfr_pkg::t_rsp                  n_out;

    logic [mbfr_pkg::ACC_W-1:0]      w_aligned;
    logic [mbfr_pkg::FIELD_W-1:0]    w_top;
    logic [mbfr_pkg::NBITS_W-1:0]    w_rshift;

    assign o_status.req_valid = i_req_valid;
    assign o_status.req_read  = (i_req.op == mbfr_pkg::OP_READ);
    assign o_status.req_wide  = i_req.num_bits > mbfr_pkg::NBITS_W'(mbfr_pkg::MAX_FIELD_BITS);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[i_req.byte_address] <= i_req.byte_data;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_mem[r_fidx[mbfr_pkg::ADDR_W-1:0]];
            r_rd_past <= r_fidx >= mbfr_pkg::FIDX_W'(mbfr_pkg::BUFFER_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off  <= i_req.bit_offset;
            r_nb   <= i_req.num_bits;
            r_err  <= o_status.req_wide;
            r_fidx <= mbfr_pkg::FIDX_W'(i_req.bit_offset >> 3);
        end else if (i_cmd.fetch) begin
            r_fidx <= r_fidx + 1'b1;
        end
        if (r_cap) begin
            r_acc <= {r_acc[mbfr_pkg::ACC_W-9:0], r_rd_past ? 8'h00 : r_rd_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap <= i_cmd.fetch;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    // drop the bit phase, then right align; width 0 shifts everything out
    always_comb begin
        w_aligned = r_acc << r_off[2:0];
        w_top     = w_aligned[mbfr_pkg::ACC_W-1 -: mbfr_pkg::FIELD_W];
        w_rshift  = mbfr_pkg::NBITS_W'(mbfr_pkg::FIELD_W) - r_nb;
        if (r_err) begin
            n_out.field_value     = '0;
            n_out.next_bit_offset = mbfr_pkg::NEXT_W'(r_off);
            n_out.width_error     = 1'b1;
        end else begin
            n_out.field_value     = w_top >> w_rshift;
            n_out.next_bit_offset = mbfr_pkg::NEXT_W'(r_off) + mbfr_pkg::NEXT_W'(r_nb);
            n_out.width_error     = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== src/mbfr_checker.sv =====
`default_nettype none
module mbfr_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           i_req_ready,
    input wire mbfr_pkg::t_req i_req_payload,
    input wire logic           i_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire mbfr_pkg::t_rsp i_rsp_payload
);

    a_reset_no_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("stalled response changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_payload.width_error |->
            i_rsp_payload.field_value == '0)
        else $error("refused width returned a non-zero field");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_payload.op == mbfr_pkg::OP_READ
            |=> !i_req_ready)
        else $error("request taken while a read is in progress");

endmodule

bind msb_first_bit_field_reader_unit mbfr_checker u_mbfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_payload (i_req.payload),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
`default_nettype wire
